[rtl/bcep_pkg.sv]
// Shared types, constants and saturating arithmetic for the biomorph pixel engine.
`timescale 1ns / 1ps

package bcep_pkg;

  // Image geometry and the axis mapping constants.
  localparam int WIDTH  = 1024;
  localparam int HEIGHT = 1024;
  localparam int HALF_W = (WIDTH / 2 == 0) ? 1 : WIDTH / 2;
  localparam int HALF_H = (HEIGHT / 2 == 0) ? 1 : HEIGHT / 2;
  localparam int ASPECT_NUM = 177;
  localparam int ASPECT_DEN = 100;
  localparam int FRAC = 24;

  localparam logic signed [63:0] SMAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] DRAW_RE_LIM = 64'd300 << FRAC;
  localparam logic [63:0] DRAW_IM_LIM = 64'd10000 << FRAC;

  // Configuration register indexes.
  localparam logic [2:0] CFG_ZOOM       = 3'd0;
  localparam logic [2:0] CFG_PAN_X      = 3'd1;
  localparam logic [2:0] CFG_PAN_Y      = 3'd2;
  localparam logic [2:0] CFG_CONST_RE   = 3'd3;
  localparam logic [2:0] CFG_CONST_IM   = 3'd4;
  localparam logic [2:0] CFG_ITER_LIMIT = 3'd5;
  localparam logic [2:0] CFG_BASE_COLOR = 3'd6;

  // Product codes, in the order the sequencer computes them.
  localparam logic [2:0] PROD_RE2 = 3'd0;
  localparam logic [2:0] PROD_IM2 = 3'd1;
  localparam logic [2:0] PROD_RE3 = 3'd2;
  localparam logic [2:0] PROD_IM3 = 3'd3;
  localparam logic [2:0] PROD_A   = 3'd4;
  localparam logic [2:0] PROD_B   = 3'd5;

  typedef struct packed {
    logic [9:0] pix_x;
    logic [9:0] pix_y;
  } pix_in_t;

  typedef struct packed {
    logic [9:0]  out_x;
    logic [9:0]  out_y;
    logic        draw;
    logic [31:0] pixel_color;
  } result_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic       load;
    logic       prep;
    logic       axis;
    logic       div_start;
    logic       map_wr;
    logic       op_ld;
    logic       acc_clr;
    logic       mul_en;
    logic [1:0] mul_part;
    logic       acc_en;
    logic [1:0] acc_part;
    logic       fix_wr;
    logic [2:0] pidx;
    logic       comb0;
    logic       comb1;
    logic       comb2;
    logic       res_wr;
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic cont;
    logic div_done;
  } stat_t;

  // Add two values and clamp to the symmetric range.
  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s > 65'(SMAX)) begin
      return SMAX;
    end else if (s < -65'(SMAX)) begin
      return -SMAX;
    end
    return s[63:0];
  endfunction

  // Triple a value and clamp to the symmetric range.
  function automatic logic signed [63:0] sat_mul3(input logic signed [63:0] a);
    logic signed [65:0] s;
    s = 66'(a) + 66'(a) + 66'(a);
    if (s > 66'(SMAX)) begin
      return SMAX;
    end else if (s < -66'(SMAX)) begin
      return -SMAX;
    end
    return s[63:0];
  endfunction

endpackage

[rtl/bcep_div.sv]
// Restoring divider, one quotient bit per cycle, for the pixel mapping.
`timescale 1ns / 1ps

module bcep_div import bcep_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] num,
  input  logic [63:0] den,
  output logic [63:0] quot,
  output logic        done
);

  logic [64:0] rem;
  logic [63:0] dvd;
  logic [5:0]  cnt;
  logic        run;
  logic [64:0] rem_sh;
  logic        fits;

  // Shift in the next dividend bit and try the subtraction.
  assign rem_sh = {rem[63:0], dvd[63]};
  assign fits   = rem_sh >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Remainder and quotient registers.
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      dvd  <= num;
      quot <= '0;
    end else if (run) begin
      rem  <= fits ? rem_sh - {1'b0, den} : rem_sh;
      dvd  <= {dvd[62:0], 1'b0};
      quot <= {quot[62:0], fits};
    end
  end

endmodule

[rtl/bcep_datapath.sv]
// Datapath: configuration registers, mapping, shared 32x32 multiplier and iteration state.
`timescale 1ns / 1ps

module bcep_datapath import bcep_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  pix_in_t     pix,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  cmd_t        cmd,
  output stat_t       stat,
  output result_t     result
);

  // Configuration registers.
  logic [31:0]        zoom;
  logic signed [31:0] pan_x;
  logic signed [31:0] pan_y;
  logic signed [31:0] const_re;
  logic signed [31:0] const_im;
  logic [9:0]         iter_limit;
  logic [23:0]        base_color;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      zoom       <= 32'd65536;
      pan_x      <= '0;
      pan_y      <= '0;
      const_re   <= '0;
      const_im   <= '0;
      iter_limit <= 10'd50;
      base_color <= 24'hFFFFFF;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_ZOOM:       zoom       <= cfg_data;
        CFG_PAN_X:      pan_x      <= cfg_data;
        CFG_PAN_Y:      pan_y      <= cfg_data;
        CFG_CONST_RE:   const_re   <= cfg_data;
        CFG_CONST_IM:   const_im   <= cfg_data;
        CFG_ITER_LIMIT: iter_limit <= cfg_data[9:0];
        CFG_BASE_COLOR: base_color <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  // Pixel latch and mapping operands.
  logic [9:0]         px;
  logic [9:0]         py;
  logic signed [12:0] off;
  logic [12:0]        off_mag;
  logic [31:0]        zoom_eff;
  logic [63:0]        div_num;
  logic [63:0]        div_den;
  logic               map_neg;
  logic [63:0]        quot;
  logic               div_done;
  logic signed [63:0] map_v;

  assign off = cmd.axis ? 13'($signed({3'b000, py})) - 13'(HALF_H)
                        : 13'($signed({3'b000, px})) - 13'(HALF_W);
  assign off_mag  = off[12] ? 13'(-off) : 13'(off);
  assign zoom_eff = (zoom == '0) ? 32'd1 : zoom;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      px <= pix.pix_x;
      py <= pix.pix_y;
    end
    if (cmd.prep) begin
      map_neg <= off[12];
      if (cmd.axis) begin
        div_num <= 64'(off_mag) << 40;
        div_den <= 64'(HALF_H) * 64'(zoom_eff);
      end else begin
        div_num <= (64'(ASPECT_NUM) * 64'(off_mag)) << 40;
        div_den <= 64'(ASPECT_DEN * HALF_W) * 64'(zoom_eff);
      end
    end
  end

  bcep_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .quot  (quot),
    .done  (div_done)
  );

  assign map_v = map_neg ? -$signed(quot) : $signed(quot);

  // Iteration state and product registers.
  logic signed [63:0] re, im, re2, im2, re3, im3, pa, pb;
  logic [9:0]         n;
  logic [63:0]        ua, ub;
  logic               neg;
  logic [63:0]        pp;
  logic [127:0]       acc;
  logic signed [63:0] op_a, op_b;
  logic [31:0]        mx, my;
  logic [62:0]        fix_mag;
  logic signed [63:0] fix_v;
  logic [127:0]       pp_sh;

  // Operand choice for the current product.
  always_comb begin
    unique case (cmd.pidx)
      PROD_RE2: begin op_a = re;  op_b = re;  end
      PROD_IM2: begin op_a = im;  op_b = im;  end
      PROD_RE3: begin op_a = re2; op_b = re;  end
      PROD_IM3: begin op_a = im2; op_b = im;  end
      PROD_A:   begin op_a = re;  op_b = im2; end
      PROD_B:   begin op_a = re2; op_b = im;  end
      default:  begin op_a = re;  op_b = re;  end
    endcase
  end

  // Partial product halves and the shift of the product being added.
  assign mx = cmd.mul_part[1] ? ua[63:32] : ua[31:0];
  assign my = cmd.mul_part[0] ? ub[63:32] : ub[31:0];

  always_comb begin
    unique case (cmd.acc_part)
      2'd0:    pp_sh = {64'd0, pp};
      2'd3:    pp_sh = {pp, 64'd0};
      default: pp_sh = {32'd0, pp, 32'd0};
    endcase
  end

  // Drop fraction bits, saturate and restore the sign.
  assign fix_mag = (acc[127:87] != '0) ? SMAX[62:0] : acc[86:24];
  assign fix_v   = neg ? -$signed({1'b0, fix_mag}) : $signed({1'b0, fix_mag});

  always_ff @(posedge clk) begin
    if (cmd.op_ld) begin
      ua  <= op_a[63] ? 64'(-op_a) : 64'(op_a);
      ub  <= op_b[63] ? 64'(-op_b) : 64'(op_b);
      neg <= op_a[63] ^ op_b[63];
    end
    if (cmd.mul_en) begin
      pp <= 64'(mx) * 64'(my);
    end
    if (cmd.acc_clr) begin
      acc <= '0;
    end else if (cmd.acc_en) begin
      acc <= acc + pp_sh;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      re <= '0;
      im <= '0;
      n  <= '0;
    end else begin
      if (cmd.load) begin
        n <= '0;
      end
      if (cmd.map_wr) begin
        if (cmd.axis) begin
          im <= sat_add(map_v, 64'(pan_y));
        end else begin
          re <= sat_add(map_v, 64'(pan_x));
        end
      end
      if (cmd.fix_wr) begin
        unique case (cmd.pidx)
          PROD_RE2: re2 <= fix_v;
          PROD_IM2: im2 <= fix_v;
          PROD_RE3: re3 <= fix_v;
          PROD_IM3: im3 <= fix_v;
          PROD_A:   pa  <= fix_v;
          PROD_B:   pb  <= fix_v;
          default: ;
        endcase
      end
      // Combine the cubes in three saturating steps.
      if (cmd.comb0) begin
        pa <= sat_mul3(pa);
        pb <= sat_mul3(pb);
      end
      if (cmd.comb1) begin
        re3 <= sat_add(re3, -pa);
        im3 <= sat_add(pb, -im3);
      end
      if (cmd.comb2) begin
        re <= sat_add(re3, 64'(const_re));
        im <= sat_add(im3, 64'(const_im));
        n  <= n + 10'd1;
      end
    end
  end

  // Loop test against the escape bound and the iteration cap.
  logic signed [63:0] bound;
  assign bound = $signed(64'(iter_limit) << FRAC);
  assign stat.cont = (re < bound) && (re > -bound) && (im < bound) && (im > -bound)
                     && (n < iter_limit);
  assign stat.div_done = div_done;

  // Result register.
  logic [63:0] re_mag, im_mag;
  logic [33:0] color_full;
  assign re_mag     = re[63] ? 64'(-re) : 64'(re);
  assign im_mag     = im[63] ? 64'(-im) : 64'(im);
  assign color_full = 34'(n) * 34'(base_color);

  always_ff @(posedge clk) begin
    if (cmd.res_wr) begin
      result.out_x       <= px;
      result.out_y       <= py;
      result.draw        <= (re_mag < DRAW_RE_LIM) && (im_mag < DRAW_IM_LIM);
      result.pixel_color <= (n < iter_limit) ? color_full[31:0] : 32'd0;
    end
  end

endmodule

[rtl/bcep_ctrl.sv]
// Controller: sequences mapping, the six products and the combine steps of each iteration.
`timescale 1ns / 1ps

module bcep_ctrl import bcep_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  output logic  busy,
  output logic  done,
  output cmd_t  cmd,
  input  stat_t stat
);

  typedef enum logic [11:0] {
    S_IDLE  = 12'b0000_0000_0001,
    S_PREP  = 12'b0000_0000_0010,
    S_GO    = 12'b0000_0000_0100,
    S_WAIT  = 12'b0000_0000_1000,
    S_TEST  = 12'b0000_0001_0000,
    S_MUL   = 12'b0000_0010_0000,
    S_FIX   = 12'b0000_0100_0000,
    S_COMB0 = 12'b0000_1000_0000,
    S_COMB1 = 12'b0001_0000_0000,
    S_COMB2 = 12'b0010_0000_0000,
    S_FIN   = 12'b0100_0000_0000,
    S_OUT   = 12'b1000_0000_0000
  } state_t;

  state_t     state, state_next;
  logic       axis, axis_next;
  logic [2:0] pidx, pidx_next;
  logic [2:0] sc, sc_next;

  assign busy = (state != S_IDLE);
  assign done = (state == S_OUT);

  // Next state and counters.
  always_comb begin
    state_next = state;
    axis_next  = axis;
    pidx_next  = pidx;
    sc_next    = sc;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_PREP;
          axis_next  = 1'b0;
        end
      end
      S_PREP: state_next = S_GO;
      S_GO:   state_next = S_WAIT;
      S_WAIT: begin
        if (stat.div_done) begin
          if (axis) begin
            state_next = S_TEST;
          end else begin
            axis_next  = 1'b1;
            state_next = S_PREP;
          end
        end
      end
      S_TEST: begin
        if (stat.cont) begin
          state_next = S_MUL;
          pidx_next  = PROD_RE2;
          sc_next    = '0;
        end else begin
          state_next = S_FIN;
        end
      end
      S_MUL: begin
        sc_next = sc + 3'd1;
        if (sc == 3'd5) begin
          state_next = S_FIX;
        end
      end
      S_FIX: begin
        sc_next = '0;
        if (pidx == PROD_B) begin
          state_next = S_COMB0;
        end else begin
          pidx_next  = pidx + 3'd1;
          state_next = S_MUL;
        end
      end
      S_COMB0: state_next = S_COMB1;
      S_COMB1: state_next = S_COMB2;
      S_COMB2: state_next = S_TEST;
      S_FIN:   state_next = S_OUT;
      S_OUT:   state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      axis  <= 1'b0;
      pidx  <= '0;
      sc    <= '0;
    end else begin
      state <= state_next;
      axis  <= axis_next;
      pidx  <= pidx_next;
      sc    <= sc_next;
    end
  end

  // Commands to the datapath.
  always_comb begin
    cmd           = '0;
    cmd.axis      = axis;
    cmd.pidx      = pidx;
    cmd.load      = (state == S_IDLE) && start;
    cmd.prep      = (state == S_PREP);
    cmd.div_start = (state == S_GO);
    cmd.map_wr    = (state == S_WAIT) && stat.div_done;
    cmd.op_ld     = (state == S_MUL) && (sc == 3'd0);
    cmd.acc_clr   = (state == S_MUL) && (sc == 3'd0);
    cmd.mul_en    = (state == S_MUL) && (sc >= 3'd1) && (sc <= 3'd4);
    cmd.mul_part  = 2'(sc - 3'd1);
    cmd.acc_en    = (state == S_MUL) && (sc >= 3'd2);
    cmd.acc_part  = 2'(sc - 3'd2);
    cmd.fix_wr    = (state == S_FIX);
    cmd.comb0     = (state == S_COMB0);
    cmd.comb1     = (state == S_COMB1);
    cmd.comb2     = (state == S_COMB2);
    cmd.res_wr    = (state == S_FIN);
  end

  // A started pixel makes the block busy in the next cycle.
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("start not taken");

  // A result strobe lasts one cycle and the block is free right after.
  a_done_once: assert property (@(posedge clk) disable iff (rst)
    done |=> (!done && !busy))
    else $error("result strobe held");

  // The divider is always waited on after it is started.
  a_div_wait: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |=> (state == S_WAIT))
    else $error("divider start without wait");

  // Products are only written back for a valid product code.
  a_pidx_ok: assert property (@(posedge clk) disable iff (rst)
    cmd.fix_wr |-> (pidx <= PROD_B))
    else $error("bad product code");

endmodule

[rtl/biomorph_cubic_escape_pixel.sv]
// Each mapping axis: operand setup, divider start, then a wait for the quotient.
// Each iteration: the loop test, six 64-bit products through one 32x32 multiplier,
// and three combine steps. Throughput: one pixel at a time, busy until done;
// the next start is taken once busy is low. Done lasts one cycle, no stall.
// Sync active-high reset: idle, default regs.
`timescale 1ns / 1ps

module biomorph_cubic_escape_pixel import bcep_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  pix_in_t     pix,
  output logic        done,
  output result_t     result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  cmd_t  cmd;
  stat_t stat;

  bcep_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd),
    .stat  (stat)
  );

  bcep_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .pix       (pix),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .result    (result)
  );

endmodule
